// File: sv/dqpc_pkg.sv
// Shared types and constants for the dual quadrature position counter.
package dqpc_pkg;

	localparam int COUNT_W     = 32;
	localparam int LEVELS_W    = 4;
	localparam int KIND_W      = 2;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 136;

	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_DELTA  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// levels: bit 0 left A, bit 1 left B, bit 2 right A, bit 3 right B
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [LEVELS_W-1:0] levels;
	} item_t;

	typedef struct packed {
		logic                       right_glitch;
		logic                       left_glitch;
		logic signed [COUNT_W-1:0]  right_delta;
		logic signed [COUNT_W-1:0]  left_delta;
		logic signed [COUNT_W-1:0]  right_position;
		logic signed [COUNT_W-1:0]  left_position;
	} result_t;

	// direction of one encoder's step, as seen from the left side
	typedef struct packed {
		logic up;
		logic down;
		logic glitch;
	} step_t;

endpackage

// File: sv/dqpc_quad_step.sv
// x4 quadrature step decode for one encoder.
module dqpc_quad_step (
	input  logic               prev_a,
	input  logic               prev_b,
	input  logic               now_a,
	input  logic               now_b,
	output dqpc_pkg::step_t    step
);

	logic a_chg;
	logic b_chg;

	assign a_chg = prev_a ^ now_a;
	assign b_chg = prev_b ^ now_b;

	always_comb begin
		step = '0;
		if (a_chg && b_chg) begin
			step.glitch = 1'b1;
		end else if (a_chg) begin
			step.up   = now_a ^ now_b;
			step.down = ~(now_a ^ now_b);
		end else if (b_chg) begin
			step.up   = ~(now_a ^ now_b);
			step.down = now_a ^ now_b;
		end
	end

endmodule

// File: sv/dqpc_counter.sv
// Position, snapshot and level state; computes the result of one word.
module dqpc_counter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  dqpc_pkg::item_t   item,
	output dqpc_pkg::result_t result
);

	logic [dqpc_pkg::COUNT_W-1:0]  left_count_q;
	logic [dqpc_pkg::COUNT_W-1:0]  right_count_q;
	logic [dqpc_pkg::COUNT_W-1:0]  left_snap_q;
	logic [dqpc_pkg::COUNT_W-1:0]  right_snap_q;
	logic [dqpc_pkg::LEVELS_W-1:0] levels_q;
	logic                          primed_q;

	logic [dqpc_pkg::COUNT_W-1:0]  left_next;
	logic [dqpc_pkg::COUNT_W-1:0]  right_next;
	logic [dqpc_pkg::COUNT_W-1:0]  left_snap_next;
	logic [dqpc_pkg::COUNT_W-1:0]  right_snap_next;
	logic [dqpc_pkg::LEVELS_W-1:0] levels_next;
	logic                          primed_next;

	dqpc_pkg::step_t left_step;
	dqpc_pkg::step_t right_step;

	dqpc_quad_step u_left (
		.prev_a (levels_q[0]),
		.prev_b (levels_q[1]),
		.now_a  (item.levels[0]),
		.now_b  (item.levels[1]),
		.step   (left_step)
	);

	dqpc_quad_step u_right (
		.prev_a (levels_q[2]),
		.prev_b (levels_q[3]),
		.now_a  (item.levels[2]),
		.now_b  (item.levels[3]),
		.step   (right_step)
	);

	always_comb begin
		left_next       = left_count_q;
		right_next      = right_count_q;
		left_snap_next  = left_snap_q;
		right_snap_next = right_snap_q;
		levels_next     = levels_q;
		primed_next     = primed_q;
		result          = '0;
		unique case (dqpc_pkg::kind_t'(item.kind))
			dqpc_pkg::KIND_SAMPLE: begin
				if (primed_q) begin
					// right encoder counts opposite to the left
					if (left_step.up) begin
						left_next = left_count_q + 1'b1;
					end else if (left_step.down) begin
						left_next = left_count_q - 1'b1;
					end
					if (right_step.up) begin
						right_next = right_count_q - 1'b1;
					end else if (right_step.down) begin
						right_next = right_count_q + 1'b1;
					end
					result.left_glitch  = left_step.glitch;
					result.right_glitch = right_step.glitch;
				end
				levels_next = item.levels;
				primed_next = 1'b1;
			end
			dqpc_pkg::KIND_DELTA: begin
				result.left_delta  = left_count_q - left_snap_q;
				result.right_delta = right_count_q - right_snap_q;
				left_snap_next     = left_count_q;
				right_snap_next    = right_count_q;
			end
			dqpc_pkg::KIND_CLEAR: begin
				left_next       = '0;
				right_next      = '0;
				left_snap_next  = '0;
				right_snap_next = '0;
				levels_next     = '0;
				primed_next     = 1'b0;
			end
			default: begin
			end
		endcase
		result.left_position  = left_next;
		result.right_position = right_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_count_q  <= '0;
			right_count_q <= '0;
			left_snap_q   <= '0;
			right_snap_q  <= '0;
			levels_q      <= '0;
			primed_q      <= 1'b0;
		end else if (en) begin
			left_count_q  <= left_next;
			right_count_q <= right_next;
			left_snap_q   <= left_snap_next;
			right_snap_q  <= right_snap_next;
			levels_q      <= levels_next;
			primed_q      <= primed_next;
		end
	end

endmodule

// File: sv/dual_quadrature_position_counter.sv
// Top level of the dual x4 quadrature position counter.
// Takes one word per clock while s_tready is high and returns one result word
// per input word. The input register feeds the decode and count update, which
// loads the result register in the cycle the word leaves the input register,
// and m_tdata shows the result register. Count state updates once per word, so
// a word sees the effect of the one before it with no gap. s_tready drops only
// while both registers hold a word and m_tready is low, and it depends on
// m_tready combinationally; with m_tready held high the block sustains one word
// per cycle. No clearing pass after reset.
module dual_quadrature_position_counter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [0] left_a, [1] left_b, [2] right_a, [3] right_b, [7:4] zero
	input  logic [dqpc_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [1:0] kind
	input  logic [dqpc_pkg::KIND_W-1:0]         s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [31:0] left_position, [63:32] right_position, [95:64] left_delta,
	// [127:96] right_delta, [128] left_glitch, [129] right_glitch, [135:130] zero
	output logic [dqpc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int PAD_W = dqpc_pkg::OUT_TDATA_W - $bits(dqpc_pkg::result_t);

	dqpc_pkg::item_t   item_s1;
	logic              valid_s1;
	dqpc_pkg::result_t result;
	dqpc_pkg::result_t result_q;
	logic              out_valid_q;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind   <= s_tuser;
			item_s1.levels <= s_tdata[dqpc_pkg::LEVELS_W-1:0];
		end
		if (advance) begin
			result_q <= result;
		end
	end

	dqpc_counter u_counter (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, result_q};

endmodule
